// ===== hw/rtl/gdt_pkg.sv =====
package gdt_pkg;

	// input function codes
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_SEARCH = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	// result status codes
	localparam logic [2:0] STS_OK         = 3'd0;
	localparam logic [2:0] STS_TABLE_FULL = 3'd1;
	localparam logic [2:0] STS_ADJ_FULL   = 3'd2;
	localparam logic [2:0] STS_NO_START   = 3'd3;
	localparam logic [2:0] STS_VISIT      = 3'd4;

	// vertex colour marks
	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_GREY  = 2'd1;
	localparam logic [1:0] COL_BLACK = 2'd2;

	// one result beat
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] vertex_label;
		logic [7:0]  discovered_at;
		logic [7:0]  finished_at;
		logic [15:0] parent_label;
		logic        has_parent;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/gdt_ram.sv =====
module gdt_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	// write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/gdt_out_reg.sv =====
module gdt_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gdt_pkg::result_t push_data,
	output logic             push_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output gdt_pkg::result_t result_data
);
	import gdt_pkg::*;

	logic    full_q;
	result_t data_q;

	assign push_ready   = !full_q || result_ready;
	assign result_valid = full_q;
	assign result_data  = data_q;

	// hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push && push_ready) begin
			full_q <= 1'b1;
		end else if (result_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			data_q <= push_data;
		end
	end

endmodule

// ===== hw/rtl/graph_dfs_timestamps.sv =====
// channel  | handshake                  | payload
// item     | item_valid / item_ready     | func, vertex_a, vertex_b
// result   | result_valid / result_ready | status, vertex_label, discovered_at,
//          |                            |   finished_at, parent_label, has_parent, last
//
// One item at a time. Insert: a label scan over the stored vertices (one label
// RAM read port), then two degree reads, a fill check and two write states.
// Search: label scan, a mark sweep over the stored vertices, then a walk of the
// adjacency lists, finishing each vertex; all walk state sits in single-port-read RAMs.
// Reset clears control state only; RAM contents are set before they are read.
// A stalled result stops the sequencer until the output register frees.
module graph_dfs_timestamps #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_DEGREE   = 16,
	parameter int LABEL_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  func,
	input  logic [15:0] vertex_a,
	input  logic [15:0] vertex_b,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  status,
	output logic [15:0] vertex_label,
	output logic [7:0]  discovered_at,
	output logic [7:0]  finished_at,
	output logic [15:0] parent_label,
	output logic        has_parent,
	output logic        last
);
	import gdt_pkg::*;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int AD  = MAX_VERTICES * MAX_DEGREE;
	localparam int AAW = $clog2(AD);
	localparam int TW  = $clog2(2 * MAX_VERTICES + 1);
	localparam int LB  = LABEL_BITS;

	typedef struct packed {
		logic [1:0]    colour;
		logic [TW-1:0] disc;
		logic          pvalid;
		logic [VW-1:0] parent;
	} mark_t;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [DW-1:0] nxt;
	} frame_t;

	typedef enum logic [18:0] {
		ST_IDLE    = 19'h00001,
		ST_FIND    = 19'h00002,
		ST_INS_RDA = 19'h00004,
		ST_INS_RDB = 19'h00008,
		ST_INS_CHK = 19'h00010,
		ST_INS_W1  = 19'h00020,
		ST_INS_W2  = 19'h00040,
		ST_RESP    = 19'h00080,
		ST_SWEEP   = 19'h00100,
		ST_START   = 19'h00200,
		ST_W_RD    = 19'h00400,
		ST_W_CMP   = 19'h00800,
		ST_W_NB    = 19'h01000,
		ST_W_CHK   = 19'h02000,
		ST_F_RD    = 19'h04000,
		ST_F_LB    = 19'h08000,
		ST_F_PL    = 19'h10000,
		ST_F_OUT   = 19'h20000,
		ST_POP     = 19'h40000
	} state_t;

	state_t        state_q;
	logic [1:0]    func_q;
	logic [LB-1:0] a_q, b_q;
	logic [CW-1:0] count_q, fidx_q;
	logic          cmp_v_s1;
	logic [VW-1:0] cmp_idx_s1;
	logic          found_a_q, found_b_q;
	logic [VW-1:0] ia_q, ib_q, sa_q, sb_q;
	logic          new_a_q, new_b_q, same_q;
	logic [1:0]    need_q;
	logic [DW-1:0] deg_a_q, deg_b_q;
	logic [2:0]    sts_q;
	logic [TW-1:0] time_q, disc_q;
	logic [CW-1:0] sp_q;
	logic [VW-1:0] top_v_q, w_q;
	logic [DW-1:0] top_nxt_q;
	logic          pv_q;
	logic [LB-1:0] vlab_q, plab_q;

	// RAM ports
	logic          lab_we;
	logic [VW-1:0] lab_waddr, lab_raddr;
	logic [LB-1:0] lab_wdata, lab_rdata;
	logic          deg_we;
	logic [VW-1:0] deg_waddr, deg_raddr;
	logic [DW-1:0] deg_wdata, deg_rdata;
	logic          adj_we;
	logic [AAW-1:0] adj_waddr, adj_raddr;
	logic [VW-1:0] adj_wdata, adj_rdata;
	logic          mark_we;
	logic [VW-1:0] mark_waddr, mark_raddr;
	mark_t         mark_wdata, mark_rdata;
	logic          stk_we;
	logic [VW-1:0] stk_waddr, stk_raddr;
	frame_t        stk_wdata, stk_rdata;

	logic          push, push_ready;
	result_t       push_data, out_data;

	// label folding and result widening
	logic [LB+15:0] ext_a, ext_b;
	logic [LB-1:0]  in_a, in_b;
	logic [LB+15:0] ext_vl, ext_pl;
	logic [TW+7:0]  ext_d, ext_f;

	assign ext_a  = {{LB{1'b0}}, vertex_a};
	assign ext_b  = {{LB{1'b0}}, vertex_b};
	assign in_a   = ext_a[LB-1:0];
	assign in_b   = ext_b[LB-1:0];
	assign ext_vl = {16'd0, vlab_q};
	assign ext_pl = {16'd0, plab_q};
	assign ext_d  = {8'd0, disc_q};
	assign ext_f  = {8'd0, time_q};

	// insert decisions taken from the two degree reads and the table fill
	logic [DW-1:0] deg_b_now;
	logic [CW:0]   fill_sum;
	logic          tbl_full, adj_full;
	logic [VW-1:0] sa_now, sb_now;
	logic [CW-1:0] cnt_p1;

	assign deg_b_now = found_b_q ? deg_rdata : '0;
	assign fill_sum  = {1'b0, count_q} + (CW + 1)'(need_q);
	assign tbl_full  = fill_sum > (CW + 1)'(MAX_VERTICES);
	assign adj_full  = same_q ? ((DW + 1)'(deg_a_q) + (DW + 1)'(2) > (DW + 1)'(MAX_DEGREE))
	                          : ((found_a_q && deg_a_q >= DW'(MAX_DEGREE)) ||
	                             (found_b_q && deg_b_now >= DW'(MAX_DEGREE)));
	assign cnt_p1    = count_q + CW'(1);
	assign sa_now    = found_a_q ? ia_q : count_q[VW-1:0];
	assign sb_now    = found_b_q ? ib_q : (same_q ? sa_now :
	                   (found_a_q ? count_q[VW-1:0] : cnt_p1[VW-1:0]));

	// walk helpers
	logic [CW-1:0] sp_m1, sp_m2;
	logic [DW-1:0] nxt_a_off;
	assign sp_m1     = sp_q - CW'(1);
	assign sp_m2     = sp_q - CW'(2);
	assign nxt_a_off = same_q ? deg_b_q + DW'(1) : deg_a_q;

	// drive RAM ports from the sequencer state
	always_comb begin
		lab_we     = 1'b0;
		lab_waddr  = sa_q;
		lab_wdata  = a_q;
		lab_raddr  = fidx_q[VW-1:0];
		deg_we     = 1'b0;
		deg_waddr  = sb_q;
		deg_wdata  = deg_b_q + DW'(1);
		deg_raddr  = top_v_q;
		adj_we     = 1'b0;
		adj_waddr  = AAW'(sb_q) * AAW'(MAX_DEGREE) + AAW'(deg_b_q);
		adj_wdata  = sa_q;
		adj_raddr  = AAW'(top_v_q) * AAW'(MAX_DEGREE) + AAW'(top_nxt_q);
		mark_we    = 1'b0;
		mark_waddr = fidx_q[VW-1:0];
		mark_wdata = '{colour: COL_WHITE, disc: '0, pvalid: 1'b0, parent: '0};
		mark_raddr = adj_rdata;
		stk_we     = 1'b0;
		stk_waddr  = sp_m1[VW-1:0];
		stk_wdata  = '{v: top_v_q, nxt: top_nxt_q};
		stk_raddr  = sp_m2[VW-1:0];
		unique case (state_q)
			ST_INS_RDA: deg_raddr = ia_q;
			ST_INS_RDB: deg_raddr = ib_q;
			ST_INS_W1: begin
				lab_we = new_a_q;
				deg_we = 1'b1;
				adj_we = 1'b1;
			end
			ST_INS_W2: begin
				lab_we    = new_b_q;
				lab_waddr = sb_q;
				lab_wdata = b_q;
				deg_we    = 1'b1;
				deg_waddr = sa_q;
				deg_wdata = same_q ? deg_b_q + DW'(2) : deg_a_q + DW'(1);
				adj_we    = 1'b1;
				adj_waddr = AAW'(sa_q) * AAW'(MAX_DEGREE) + AAW'(nxt_a_off);
				adj_wdata = sb_q;
			end
			ST_SWEEP: mark_we = 1'b1;
			ST_START: begin
				mark_we    = 1'b1;
				mark_waddr = ia_q;
				mark_wdata = '{colour: COL_GREY, disc: TW'(1), pvalid: 1'b0, parent: '0};
			end
			ST_W_CHK: begin
				mark_waddr = w_q;
				mark_wdata = '{colour: COL_GREY, disc: time_q + TW'(1), pvalid: 1'b1,
				               parent: top_v_q};
				if ({1'b0, w_q} < count_q && mark_rdata.colour == COL_WHITE &&
				    sp_q < CW'(MAX_VERTICES)) begin
					mark_we = 1'b1;
					stk_we  = 1'b1;
				end
			end
			ST_F_RD: begin
				mark_raddr = top_v_q;
				lab_raddr  = top_v_q;
			end
			ST_F_LB: begin
				mark_we    = 1'b1;
				mark_waddr = top_v_q;
				mark_wdata = '{colour: COL_BLACK, disc: mark_rdata.disc,
				               pvalid: mark_rdata.pvalid, parent: mark_rdata.parent};
				lab_raddr  = mark_rdata.parent;
			end
			default: ;
		endcase
	end

	// result beat
	always_comb begin
		push      = 1'b0;
		push_data = '{status: sts_q, vertex_label: '0, discovered_at: '0, finished_at: '0,
		              parent_label: '0, has_parent: 1'b0, last: 1'b1};
		if (state_q == ST_RESP) begin
			push = 1'b1;
		end else if (state_q == ST_F_OUT) begin
			push      = 1'b1;
			push_data = '{status: STS_VISIT, vertex_label: ext_vl[15:0],
			              discovered_at: ext_d[7:0], finished_at: ext_f[7:0],
			              parent_label: ext_pl[15:0], has_parent: pv_q,
			              last: sp_q == CW'(1)};
		end
	end

	assign item_ready = state_q == ST_IDLE;

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cmp_v_s1 <= 1'b0;
			sp_q     <= '0;
			time_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cmp_v_s1 <= 1'b0;
					if (item_valid) begin
						case (func)
							FUNC_INSERT, FUNC_SEARCH: state_q <= ST_FIND;
							FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= ST_RESP;
							end
							default: ;
						endcase
					end
				end
				ST_FIND: begin
					cmp_v_s1 <= fidx_q < count_q;
					if (!(fidx_q < count_q) && !cmp_v_s1) begin
						if (func_q == FUNC_SEARCH) begin
							state_q <= found_a_q ? ST_SWEEP : ST_RESP;
						end else begin
							state_q <= ST_INS_RDA;
						end
					end
				end
				ST_INS_RDA: state_q <= ST_INS_RDB;
				ST_INS_RDB: state_q <= ST_INS_CHK;
				ST_INS_CHK: state_q <= (tbl_full || adj_full) ? ST_RESP : ST_INS_W1;
				ST_INS_W1: state_q <= ST_INS_W2;
				ST_INS_W2: begin
					count_q <= count_q + CW'(need_q);
					state_q <= ST_RESP;
				end
				ST_RESP: if (push_ready) state_q <= ST_IDLE;
				ST_SWEEP: if (fidx_q == count_q - CW'(1)) state_q <= ST_START;
				ST_START: begin
					time_q  <= TW'(1);
					sp_q    <= CW'(1);
					state_q <= ST_W_RD;
				end
				ST_W_RD: state_q <= ST_W_CMP;
				ST_W_CMP: state_q <= (top_nxt_q < deg_rdata) ? ST_W_NB : ST_F_RD;
				ST_W_NB: state_q <= ST_W_CHK;
				ST_W_CHK: begin
					if (mark_we) begin
						time_q <= time_q + TW'(1);
						sp_q   <= sp_q + CW'(1);
					end
					state_q <= ST_W_RD;
				end
				ST_F_RD: state_q <= ST_F_LB;
				ST_F_LB: begin
					time_q  <= time_q + TW'(1);
					state_q <= ST_F_PL;
				end
				ST_F_PL: state_q <= ST_F_OUT;
				ST_F_OUT: begin
					if (push_ready) begin
						sp_q    <= sp_m1;
						state_q <= (sp_q == CW'(1)) ? ST_IDLE : ST_POP;
					end
				end
				ST_POP: state_q <= ST_W_RD;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				func_q    <= func;
				a_q       <= in_a;
				b_q       <= in_b;
				fidx_q    <= '0;
				found_a_q <= 1'b0;
				found_b_q <= 1'b0;
				ia_q      <= '0;
				ib_q      <= '0;
				sts_q     <= STS_OK;
			end
			ST_FIND: begin
				if (fidx_q < count_q) begin
					fidx_q     <= fidx_q + CW'(1);
					cmp_idx_s1 <= fidx_q[VW-1:0];
				end else if (!cmp_v_s1) begin
					fidx_q <= '0;
				end
				if (cmp_v_s1 && lab_rdata == a_q && !found_a_q) begin
					found_a_q <= 1'b1;
					ia_q      <= cmp_idx_s1;
				end
				if (cmp_v_s1 && lab_rdata == b_q && !found_b_q) begin
					found_b_q <= 1'b1;
					ib_q      <= cmp_idx_s1;
				end
				sts_q  <= STS_NO_START;
				same_q <= a_q == b_q;
			end
			ST_INS_RDA: need_q <= 2'(!found_a_q) + 2'(!found_b_q && !same_q);
			ST_INS_RDB: deg_a_q <= found_a_q ? deg_rdata : '0;
			ST_INS_CHK: begin
				deg_b_q <= deg_b_now;
				sa_q    <= sa_now;
				sb_q    <= sb_now;
				new_a_q <= !found_a_q;
				new_b_q <= !found_b_q && !same_q;
				sts_q   <= tbl_full ? STS_TABLE_FULL : (adj_full ? STS_ADJ_FULL : STS_OK);
			end
			ST_SWEEP: fidx_q <= fidx_q + CW'(1);
			ST_START: begin
				top_v_q   <= ia_q;
				top_nxt_q <= '0;
			end
			ST_W_CMP: if (top_nxt_q < deg_rdata) top_nxt_q <= top_nxt_q + DW'(1);
			ST_W_NB: w_q <= adj_rdata;
			ST_W_CHK: begin
				if (mark_we) begin
					top_v_q   <= w_q;
					top_nxt_q <= '0;
				end
			end
			ST_F_LB: begin
				vlab_q <= lab_rdata;
				disc_q <= mark_rdata.disc;
				pv_q   <= mark_rdata.pvalid;
			end
			ST_F_PL: plab_q <= pv_q ? lab_rdata : '0;
			ST_POP: begin
				top_v_q   <= stk_rdata.v;
				top_nxt_q <= stk_rdata.nxt;
			end
			default: ;
		endcase
	end

	gdt_ram #(.W(LB), .D(MAX_VERTICES)) u_label (
		.clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
		.raddr(lab_raddr), .rdata(lab_rdata)
	);

	gdt_ram #(.W(DW), .D(MAX_VERTICES)) u_degree (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.raddr(deg_raddr), .rdata(deg_rdata)
	);

	gdt_ram #(.W(VW), .D(AD)) u_adjacency (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	gdt_ram #(.W($bits(mark_t)), .D(MAX_VERTICES)) u_mark (
		.clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
		.raddr(mark_raddr), .rdata(mark_rdata)
	);

	gdt_ram #(.W($bits(frame_t)), .D(MAX_VERTICES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	gdt_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.push_ready(push_ready), .result_valid(result_valid),
		.result_ready(result_ready), .result_data(out_data)
	);

	assign status        = out_data.status;
	assign vertex_label  = out_data.vertex_label;
	assign discovered_at = out_data.discovered_at;
	assign finished_at   = out_data.finished_at;
	assign parent_label  = out_data.parent_label;
	assign has_parent    = out_data.has_parent;
	assign last          = out_data.last;

	// walk depth and table fill stay in range
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_VERTICES))
		else $error("walk stack overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_VERTICES))
		else $error("vertex count overflow");

	// a finish beat taken with an empty walk below it closes the search
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_OUT && push_ready && sp_q == CW'(1)) |=> state_q == ST_IDLE)
		else $error("search did not end after last finish");

	// a push is only made while the sequencer waits in a result state
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_q == ST_RESP || state_q == ST_F_OUT))
		else $error("result pushed outside a result state");

	// never read a parent frame from an empty stack
	a_pop_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |-> sp_q >= CW'(1))
		else $error("pop from an empty walk stack");

endmodule
